[hdl/value_rank_indexer_top_defines.svh]
// Assertion macros shared by the value rank indexer RTL.
`ifndef VALUE_RANK_INDEXER_TOP_DEFINES_SVH
`define VALUE_RANK_INDEXER_TOP_DEFINES_SVH

// The condition must never hold while out of reset.
`define VRI_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define VRI_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the same cycle as the trigger.
`define VRI_ASSERT_SAME(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);

`endif

[hdl/vri_pkg.sv]
// Package with the sizes, types and state codes of the value rank indexer.
`timescale 1ns / 1ps
`default_nettype none

package vri_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int VALUE_BITS = 32;
  localparam int RANK_BITS  = $clog2(MAX_ITEMS + 1);
  localparam int IDX_BITS   = $clog2(MAX_ITEMS);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_EMIT
  } vri_state_e;

  // A value traveling down the chain with its running rank.
  typedef struct packed {
    logic                  vld;
    logic [VALUE_BITS-1:0] key;
    logic [RANK_BITS-1:0]  cnt;
  } vri_pass_t;

  // Controls broadcast from the sequencer to every cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } vri_ctrl_t;

endpackage

`default_nettype wire

[hdl/vri_cell.sv]
// One compare-and-count cell of the rank chain.
`timescale 1ns / 1ps
`default_nettype none

module vri_cell
  import vri_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire vri_ctrl_t            ctrl_i,
  input  wire vri_pass_t            pass_i,
  output vri_pass_t                 pass_o,
  input  wire logic [RANK_BITS-1:0] cnt_next_i,
  output logic [RANK_BITS-1:0]      cnt_o,
  output logic                      occ_o
);

  logic                  occ_q, occ_d;
  logic [VALUE_BITS-1:0] key_q, key_d;
  logic [RANK_BITS-1:0]  cnt_q, cnt_d;
  logic                  pvld_q, pvld_d;
  logic [VALUE_BITS-1:0] pkey_q, pkey_d;
  logic [RANK_BITS-1:0]  pcnt_q, pcnt_d;
  logic                  le_pass;
  logic                  le_own;

  // Stored value at or below the passing one, and the other way round.
  assign le_pass = $signed(key_q) <= $signed(pass_i.key);
  assign le_own  = $signed(pass_i.key) <= $signed(key_q);

  always_comb begin
    occ_d  = occ_q;
    key_d  = key_q;
    cnt_d  = cnt_q;
    pvld_d = 1'b0;
    pkey_d = pass_i.key;
    pcnt_d = pass_i.cnt;
    if (ctrl_i.clear) begin
      occ_d = 1'b0;
    end else if (ctrl_i.shift) begin
      cnt_d = cnt_next_i;
    end else if (pass_i.vld) begin
      if (!occ_q) begin
        // First free cell: the value settles here with its count so far.
        occ_d = 1'b1;
        key_d = pass_i.key;
        cnt_d = pass_i.cnt;
      end else begin
        pvld_d = 1'b1;
        if (le_pass) begin
          pcnt_d = pass_i.cnt + RANK_BITS'(1);
        end
        if (le_own) begin
          cnt_d = cnt_q + RANK_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= 1'b0;
      pvld_q <= 1'b0;
    end else begin
      occ_q  <= occ_d;
      pvld_q <= pvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    cnt_q  <= cnt_d;
    pkey_q <= pkey_d;
    pcnt_q <= pcnt_d;
  end

  assign pass_o.vld = pvld_q;
  assign pass_o.key = pkey_q;
  assign pass_o.cnt = pcnt_q;
  assign cnt_o      = cnt_q;
  assign occ_o      = occ_q;

endmodule

`default_nettype wire

[hdl/value_rank_indexer_top.sv]
// Requests are taken one per cycle while a set loads; each value walks down the cell chain
// and settles in the first free cell. After the last request, results start once the newest
// value has reached its cell, then leave one per cycle while the output is not stalled.
// Input stalls from the last request until the final result of the set is taken.
// Reset clears the sequencer, the item count and every cell's occupied flag at once.
`timescale 1ns / 1ps
`default_nettype none

module value_rank_indexer_top
  import vri_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [VALUE_BITS-1:0] value_i,
  input  wire logic                  last_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [RANK_BITS-1:0]       rank_o,
  output logic                       last_res_o
);

`include "value_rank_indexer_top_defines.svh"

  vri_state_e           state_q, state_d;
  logic [RANK_BITS-1:0] count_q, count_d;
  logic [RANK_BITS-1:0] remain_q, remain_d;
  logic [IDX_BITS-1:0]  newest_idx;
  logic                 full;
  logic                 in_acc;
  logic                 out_acc;
  vri_ctrl_t            ctrl;
  vri_pass_t            chain_w [MAX_ITEMS+1];
  logic [RANK_BITS-1:0] cnt_w   [MAX_ITEMS+1];
  logic [MAX_ITEMS-1:0] occ_w;
  logic                 rank_ok;
  logic                 set_empty;
  logic                 remain_ok;

  assign in_stall_o  = state_q != ST_LOAD;
  assign out_valid_o = state_q == ST_EMIT;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign full        = count_q == RANK_BITS'(MAX_ITEMS);
  assign newest_idx  = IDX_BITS'(count_q - RANK_BITS'(1));

  // A value beyond the store size never enters the chain.
  assign chain_w[0].vld      = in_acc && !full;
  assign chain_w[0].key      = value_i;
  assign chain_w[0].cnt      = RANK_BITS'(1);
  assign cnt_w[MAX_ITEMS]    = '0;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    vri_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .pass_i     (chain_w[i]),
      .pass_o     (chain_w[i+1]),
      .cnt_next_i (cnt_w[i+1]),
      .cnt_o      (cnt_w[i]),
      .occ_o      (occ_w[i])
    );
  end

  assign rank_o     = cnt_w[0];
  assign last_res_o = remain_q == RANK_BITS'(1);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    remain_d   = remain_q;
    ctrl.shift = 1'b0;
    ctrl.clear = 1'b0;
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (!full) begin
            count_d = count_q + RANK_BITS'(1);
          end
          if (last_i) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        // Values settle in order, so the newest one settling means all have.
        if (occ_w[newest_idx]) begin
          remain_d = count_q;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          ctrl.shift = 1'b1;
          remain_d   = remain_q - RANK_BITS'(1);
          if (last_res_o) begin
            ctrl.clear = 1'b1;
            count_d    = '0;
            state_d    = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      count_q  <= '0;
      remain_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      remain_q <= remain_d;
    end
  end

  assign rank_ok   = (rank_o != '0) && (rank_o <= RANK_BITS'(MAX_ITEMS));
  assign set_empty = (count_q == '0) && (occ_w == '0);
  assign remain_ok = (remain_q != '0) && (remain_q <= count_q);

  `VRI_ASSERT_NEVER(a_no_overrun, chain_w[MAX_ITEMS].vld, "value ran off the end of the chain")
  `VRI_ASSERT_SAME(a_rank_range, out_valid_o, rank_ok, "rank out of range")
  `VRI_ASSERT_NEXT(a_set_cleared, out_acc && last_res_o, set_empty, "store not cleared after the set")
  `VRI_ASSERT_SAME(a_emit_nonempty, out_valid_o, remain_ok, "result counter out of step")

endmodule

`default_nettype wire
